// ===== design/tcs_pkg.sv =====
// ----------------------------------------------------------------------------
// tcs_pkg: shared types and constants of the temporal centroid / spread unit
// Holds the sequencer state and step encodings, register indexes, field
// widths and the fixed widths of the exact moment datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tcs_pkg;

  // Field widths.
  localparam int SAMPLE_W   = 16;
  localparam int TIME_W     = 48;
  localparam int COUNT_W    = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int PERIOD_W   = 32;

  // Moment accumulators, wide enough for the largest supported frame.
  localparam int S0_W = 33;
  localparam int S1_W = 48;
  localparam int S2_W = 64;

  // End-of-frame datapath.
  localparam int ACC_W  = 160;
  localparam int MX_W   = 128;
  localparam int MY_W   = 64;
  localparam int LIMB_W = 32;
  localparam int CNT_W  = 8;

  localparam logic [CNT_W-1:0] DIV_LAST  = 8'd159;
  localparam logic [CNT_W-1:0] SQRT_LAST = 8'd47;
  localparam logic [2:0]       MUL_LAST  = 3'd7;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd89478;

  localparam logic [TIME_W-1:0] CEN_POS_SAT = 48'h7FFF_FFFF_FFFF;
  localparam logic [TIME_W-1:0] CEN_NEG_SAT = 48'h8000_0000_0000;
  localparam logic [TIME_W-1:0] SPR_SAT     = 48'hFFFF_FFFF_FFFF;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_MODE   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_ACC3,
    ST_EVAL,
    ST_MSET,
    ST_MUL,
    ST_MDRAIN,
    ST_POST,
    ST_DIV,
    ST_DDONE,
    ST_COMB,
    ST_NEG,
    ST_SQRT,
    ST_OUT
  } state_t;

  // Multiply steps of the end-of-frame program, in order.
  typedef enum logic [2:0] {
    OP_SQ0,  // |S0| * |S0|
    OP_CEN,  // |S1| * T, then divided by |S0|
    OP_P,    // |S2| * |S0|
    OP_Q,    // |S1| * |S1|
    OP_DT,   // D * T
    OP_DTT   // D * T * T, then divided by S0^2
  } op_t;

endpackage

`default_nettype wire

// ===== design/temporal_centroid_spread_unit.sv =====
// ----------------------------------------------------------------------------
// temporal_centroid_spread_unit: time centroid and spread of an audio frame
// Accumulates exact moments S0, S1, S2 per sample and, at the end of a frame,
// derives centroid and spread with one shared multiplier and one shared
// adder under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  cfg      | cfg_write             | cfg_index, cfg_data
//  in       | in_valid / in_ready   | sample, frame_end
//  out      | out_valid / out_ready | centroid_seconds, spread_seconds,
//           |                       | zero_weight, saturated, frame_overflow,
//           |                       | sample_count
//
//  A sample word is accepted in ST_IDLE, passes twice through the shared
//  33x33 multiplier (x*i in ST_MUL1, then x*i^2 in ST_MUL2) and updates the
//  index in ST_ACC3. After a word with frame_end the sequencer runs six
//  limb-wise products, two passes of 160 steps on the bit-serial divider
//  and 48 root steps.
//  Frames in another domain or with a zero sum go from ST_EVAL to ST_OUT.
//  A finished result waits in the output register while samples of the next
//  frame are accepted; only the next frame end stalls on a full output.
//  Synchronous reset clears the moments and out_valid and resets the registers.

`default_nettype none

module temporal_centroid_spread_unit #(
  parameter int FRAME_MAX = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tcs_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [tcs_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 frame_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tcs_pkg::TIME_W-1:0]    centroid_seconds,
  output logic [tcs_pkg::TIME_W-1:0]           spread_seconds,
  output logic                                 zero_weight,
  output logic                                 saturated,
  output logic                                 frame_overflow,
  output logic [tcs_pkg::COUNT_W-1:0]          sample_count
);

  import tcs_pkg::*;

  localparam int IDX_W = $clog2(FRAME_MAX + 1);
  localparam int ISQ_W = 2 * IDX_W;

  state_t state, state_next;
  op_t    op;

  // Configuration.
  logic [PERIOD_W-1:0] sample_period;
  logic                domain_mode;

  // Per-sample state.
  logic signed [SAMPLE_W-1:0] smp;
  logic                       fend;
  logic [IDX_W-1:0]           idx;
  logic [ISQ_W-1:0]           isq;
  logic                       ovf_seen;
  logic signed [S0_W-1:0]     wsum;
  logic signed [S1_W-1:0]     m1;
  logic signed [S2_W-1:0]     m2;

  // End-of-frame datapath.
  logic [31:0]         a0;
  logic [46:0]         a1;
  logic [62:0]         a2;
  logic                cen_neg;
  logic                add_mode;
  logic [MX_W-1:0]     mx;
  logic [MY_W-1:0]     my;
  logic [2:0]          k;
  logic [63:0]         prod;
  logic [2:0]          prod_sh;
  logic [ACC_W-1:0]    acc;
  logic [63:0]         rem;
  logic [TIME_W-1:0]   root;
  logic [CNT_W-1:0]    cnt;
  logic [63:0]         dv_sq;
  logic [95:0]         pv;

  // Finished result.
  logic [TIME_W-1:0]   res_cen;
  logic [TIME_W-1:0]   res_spr;
  logic                res_zw;
  logic                res_sat;
  logic                res_ovf;
  logic [COUNT_W-1:0]  res_cnt;

  // Combinational signals.
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  mul_p;
  logic [ACC_W-1:0]    au_a, au_b, au_b_eff;
  logic                au_sub;
  logic [ACC_W:0]      au_sum;
  logic                au_ge;
  logic                acc_add;
  logic                out_load;
  logic [ACC_W-1:0]    prod_shifted;
  logic [64:0]         div_sh;
  logic [51:0]         sq_sh;
  logic [TIME_W-1:0]   root_next;
  logic [63:0]         dvs_sel;
  logic [S0_W-1:0]     wsum_mag;
  logic [S1_W-1:0]     m1_mag;
  logic [S2_W-1:0]     m2_mag;
  logic [2:0]          mul_sh;
  logic                cen_hi;
  logic [TIME_W-1:0]   cen_q;
  logic                cen_sat;
  logic [TIME_W-1:0]   cen_val;
  logic                idx_room;

  assign idx_room     = idx < IDX_W'(FRAME_MAX);
  assign mul_p        = mul_a * mul_b;
  assign mul_sh       = {1'b0, k[2:1]} + {2'b00, k[0]};
  assign prod_shifted = ACC_W'(prod) << {prod_sh, 5'd0};
  assign div_sh       = {rem, acc[ACC_W-1]};
  assign sq_sh        = {rem[49:0], acc[95:94]};
  assign dvs_sel      = (op == OP_CEN) ? 64'(a0) : dv_sq;
  assign au_b_eff     = au_sub ? ~au_b : au_b;
  assign au_sum       = {1'b0, au_a} + {1'b0, au_b_eff} + (ACC_W + 1)'(au_sub);
  assign au_ge        = au_sum[ACC_W];
  assign root_next    = {root[TIME_W-2:0], au_ge};

  assign wsum_mag = wsum[S0_W-1] ? (S0_W'(0) - wsum) : wsum;
  assign m1_mag   = m1[S1_W-1] ? (S1_W'(0) - m1) : m1;
  assign m2_mag   = m2[S2_W-1] ? (S2_W'(0) - m2) : m2;

  // Centroid from the quotient in acc; a negative result may reach -2^47.
  assign cen_hi  = |acc[ACC_W-1:TIME_W];
  assign cen_q   = acc[TIME_W-1:0];
  assign cen_sat = cen_neg ? (cen_hi || (cen_q[TIME_W-1] && |cen_q[TIME_W-2:0]))
                           : (cen_hi || cen_q[TIME_W-1]);
  always_comb begin
    if (cen_neg) begin
      cen_val = cen_sat ? CEN_NEG_SAT : (TIME_W'(0) - cen_q);
    end else begin
      cen_val = cen_sat ? CEN_POS_SAT : cen_q;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (idx_room) begin
            state_next = ST_MUL1;
          end else if (frame_end) begin
            state_next = ST_EVAL;
          end
        end
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_ACC3;
      ST_ACC3: state_next = fend ? ST_EVAL : ST_IDLE;
      ST_EVAL: begin
        if (domain_mode || wsum == '0) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_MSET;
        end
      end
      ST_MSET: state_next = ST_MUL;
      ST_MUL: begin
        if (k == MUL_LAST) begin
          state_next = ST_MDRAIN;
        end
      end
      ST_MDRAIN: state_next = ST_POST;
      ST_POST: begin
        unique case (op)
          OP_CEN, OP_DTT: state_next = ST_DIV;
          OP_Q:           state_next = ST_COMB;
          default:        state_next = ST_MSET;
        endcase
      end
      ST_DIV: begin
        if (cnt == DIV_LAST) begin
          state_next = ST_DDONE;
        end
      end
      ST_DDONE: begin
        if (op == OP_CEN) begin
          state_next = ST_MSET;
        end else if (|acc[ACC_W-1:96]) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_SQRT;
        end
      end
      ST_COMB: state_next = (!add_mode && !au_ge) ? ST_NEG : ST_MSET;
      ST_NEG:  state_next = ST_MSET;
      ST_SQRT: begin
        if (cnt == SQRT_LAST) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control: handshake, multiplier and shared adder operands.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    acc_add  = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    au_a     = '0;
    au_b     = '0;
    au_sub   = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_MUL1: begin
        mul_a = 33'(smp);
        mul_b = {1'b0, 32'(idx)};
      end
      ST_MUL2: begin
        mul_a = 33'(smp);
        mul_b = {1'b0, 32'(isq)};
      end
      ST_MUL: begin
        mul_a   = {1'b0, mx[{k[2:1], 5'd0} +: LIMB_W]};
        mul_b   = {1'b0, my[{k[0], 5'd0} +: LIMB_W]};
        acc_add = (k != 3'd0);
        au_a    = acc;
        au_b    = prod_shifted;
      end
      ST_MDRAIN: begin
        acc_add = 1'b1;
        au_a    = acc;
        au_b    = prod_shifted;
      end
      ST_DIV: begin
        au_a   = ACC_W'(div_sh);
        au_b   = ACC_W'(dvs_sel);
        au_sub = 1'b1;
      end
      ST_SQRT: begin
        au_a   = ACC_W'(sq_sh);
        au_b   = ACC_W'({root, 2'b01});
        au_sub = 1'b1;
      end
      ST_COMB: begin
        au_a   = ACC_W'(pv);
        au_b   = acc;
        au_sub = !add_mode;
      end
      ST_NEG: begin
        au_b   = acc;
        au_sub = 1'b1;
      end
      ST_OUT: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // Control state, configuration and moment accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sample_period <= PERIOD_RESET;
      domain_mode   <= 1'b0;
      idx           <= '0;
      isq           <= '0;
      ovf_seen      <= 1'b0;
      wsum          <= '0;
      m1            <= '0;
      m2            <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SAMPLE_PERIOD: sample_period <= cfg_data;
          REG_DOMAIN_MODE:   domain_mode   <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == ST_IDLE && in_valid && !idx_room) begin
        ovf_seen <= 1'b1;
      end
      if (state == ST_MUL1) begin
        wsum <= wsum + S0_W'(smp);
      end
      if (state == ST_MUL2) begin
        m1 <= m1 + S1_W'(prod);
      end
      if (state == ST_ACC3) begin
        m2  <= m2 + prod;
        idx <= idx + 1'b1;
        isq <= isq + ISQ_W'({idx, 1'b1});
      end
      if (state == ST_EVAL) begin
        wsum     <= '0;
        m1       <= '0;
        m2       <= '0;
        idx      <= '0;
        isq      <= '0;
        ovf_seen <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      smp  <= sample;
      fend <= frame_end;
    end
    if (state == ST_MUL1 || state == ST_MUL2 || state == ST_MUL) begin
      prod    <= mul_p[63:0];
      prod_sh <= mul_sh;
    end
    if (acc_add) begin
      acc <= au_sum[ACC_W-1:0];
    end
    unique case (state)
      ST_EVAL: begin
        a0       <= wsum_mag[31:0];
        a1       <= m1_mag[46:0];
        a2       <= m2_mag[62:0];
        cen_neg  <= m1[S1_W-1] != wsum[S0_W-1];
        add_mode <= m2[S2_W-1] != wsum[S0_W-1];
        op       <= OP_SQ0;
        res_zw   <= !domain_mode && (wsum == '0);
        res_cen  <= '0;
        res_spr  <= '0;
        res_sat  <= 1'b0;
        res_ovf  <= ovf_seen;
        res_cnt  <= COUNT_W'(idx);
      end
      ST_MSET: begin
        acc <= '0;
        k   <= '0;
        unique case (op)
          OP_SQ0: begin
            mx <= MX_W'(a0);
            my <= MY_W'(a0);
          end
          OP_CEN: begin
            mx <= MX_W'(a1);
            my <= MY_W'(sample_period);
          end
          OP_P: begin
            mx <= MX_W'(a2);
            my <= MY_W'(a0);
          end
          OP_Q: begin
            mx <= MX_W'(a1);
            my <= MY_W'(a1);
          end
          OP_DT, OP_DTT: begin
            mx <= acc[MX_W-1:0];
            my <= MY_W'(sample_period);
          end
          default: ;
        endcase
      end
      ST_MUL: k <= k + 1'b1;
      ST_POST: begin
        rem <= '0;
        cnt <= '0;
        unique case (op)
          OP_SQ0: begin
            dv_sq <= acc[63:0];
            op    <= OP_CEN;
          end
          OP_P: begin
            pv <= acc[95:0];
            op <= OP_Q;
          end
          OP_DT: op <= OP_DTT;
          default: ;
        endcase
      end
      ST_DIV: begin
        // Restoring division: one quotient bit enters acc at the bottom.
        rem <= au_ge ? au_sum[63:0] : div_sh[63:0];
        acc <= {acc[ACC_W-2:0], au_ge};
        cnt <= cnt + 1'b1;
      end
      ST_DDONE: begin
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        if (op == OP_CEN) begin
          res_cen <= cen_val;
          res_sat <= cen_sat;
          op      <= OP_P;
        end else if (|acc[ACC_W-1:96]) begin
          res_spr <= SPR_SAT;
          res_sat <= 1'b1;
        end
      end
      ST_COMB, ST_NEG: begin
        acc <= au_sum[ACC_W-1:0];
        op  <= OP_DT;
      end
      ST_SQRT: begin
        // Digit-by-digit root: two radicand bits per step.
        rem  <= au_ge ? 64'(au_sum[51:0]) : 64'(sq_sh);
        root <= root_next;
        acc  <= {acc[ACC_W-3:0], 2'b00};
        cnt  <= cnt + 1'b1;
        if (cnt == SQRT_LAST) begin
          res_spr <= root_next;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      centroid_seconds <= res_cen;
      spread_seconds   <= res_spr;
      zero_weight      <= res_zw;
      saturated        <= res_sat;
      frame_overflow   <= res_ovf;
      sample_count     <= res_cnt;
    end
  end

  // A result word appears only from the output step of the sequencer.
  property p_out_from_seq;
    @(posedge clk) disable iff (rst)
      $rose(out_valid) |-> $past(state == ST_OUT);
  endproperty
  a_out_from_seq: assert property (p_out_from_seq)
    else $error("result word raised outside the output step");

  // The sample index never runs past the frame capacity.
  property p_idx_bound;
    @(posedge clk) disable iff (rst)
      idx <= IDX_W'(FRAME_MAX);
  endproperty
  a_idx_bound: assert property (p_idx_bound)
    else $error("sample index beyond frame capacity");

  // The division remainder stays below the divisor.
  property p_div_rem;
    @(posedge clk) disable iff (rst)
      (state == ST_DIV) |-> (rem < dvs_sel);
  endproperty
  a_div_rem: assert property (p_div_rem)
    else $error("division remainder not below divisor");

  // The root remainder never exceeds twice the partial root.
  property p_sqrt_rem;
    @(posedge clk) disable iff (rst)
      (state == ST_SQRT) |-> (rem <= 64'({root, 1'b0}));
  endproperty
  a_sqrt_rem: assert property (p_sqrt_rem)
    else $error("root remainder out of range");

  // A zero-sum frame is never reported as clipped.
  property p_zw_sat;
    @(posedge clk) disable iff (rst)
      out_valid |-> !(zero_weight && saturated);
  endproperty
  a_zw_sat: assert property (p_zw_sat)
    else $error("zero weight and saturation reported together");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for temporal_centroid_spread_unit
// Streams framed audio samples through the valid/ready input, predicts the
// centroid, spread and status flags of every frame with exact wide integer
// arithmetic, and compares each output word field by field. Random gaps on
// both sides and several register settings.
// ----------------------------------------------------------------------------

module tb;
  import tcs_pkg::*;

  localparam int FRAME_MAX   = 4096;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_WORDS = 100;
  localparam int N_PHASES    = 8;

  typedef bit [255:0] wide_t;

  typedef struct {
    logic [TIME_W-1:0]  centroid;
    logic [TIME_W-1:0]  spread;
    logic               zero_weight;
    logic               saturated;
    logic               overflow;
    logic [COUNT_W-1:0] count;
  } frame_result_t;

  // Keeps its own copy of the moments and registers and queues the result
  // that each finished frame should produce.
  class centroid_checker;
    bit [PERIOD_W-1:0] period;
    bit                other_domain;
    longint            w_sum;
    longint            m1;
    longint            m2;
    int                used;
    bit                overflowed;
    frame_result_t     pending[$];
    int                errors;
    int                frames_checked;

    function new();
      period = PERIOD_RESET;
      other_domain = 1'b0;
      errors = 0;
      frames_checked = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      w_sum = 0;
      m1 = 0;
      m2 = 0;
      used = 0;
      overflowed = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SAMPLE_PERIOD: period = data;
        REG_DOMAIN_MODE:   other_domain = data[0];
        default: ;
      endcase
    endfunction

    function wide_t mag(longint v);
      return (v < 0) ? wide_t'(-v) : wide_t'(v);
    endfunction

    function frame_result_t frame_features();
      frame_result_t r;
      wide_t a0, a1, c, p, q, d, cand, y;
      bit neg;
      int b;
      r.centroid = '0;
      r.spread = '0;
      r.zero_weight = 1'b0;
      r.saturated = 1'b0;
      r.overflow = overflowed;
      r.count = used[COUNT_W-1:0];
      if (other_domain) return r;
      if (w_sum == 0) begin
        r.zero_weight = 1'b1;
        return r;
      end
      a0 = mag(w_sum);
      a1 = mag(m1);
      neg = (m1 < 0) != (w_sum < 0);
      c = a1 * period / a0;
      if (neg) begin
        if (c > wide_t'(CEN_NEG_SAT)) begin
          r.centroid = CEN_NEG_SAT;
          r.saturated = 1'b1;
        end else begin
          r.centroid = ~c[TIME_W-1:0] + 1'b1;
        end
      end else if (c > wide_t'(CEN_POS_SAT)) begin
        r.centroid = CEN_POS_SAT;
        r.saturated = 1'b1;
      end else begin
        r.centroid = c[TIME_W-1:0];
      end
      // The variance numerator |S2*S0 - S1^2| keeps its sign bookkeeping on
      // magnitudes, so opposite signs of S2 and S0 turn the difference into a sum.
      p = mag(m2) * a0;
      q = a1 * a1;
      if ((m2 < 0) != (w_sum < 0)) d = p + q;
      else if (p >= q) d = p - q;
      else d = q - p;
      d = d * period * period / a0 / a0;
      if ((d >> 96) != 0) begin
        r.spread = SPR_SAT;
        r.saturated = 1'b1;
      end else begin
        y = 0;
        for (b = TIME_W - 1; b >= 0; b--) begin
          cand = y | (wide_t'(1) << b);
          if (cand * cand <= d) y = cand;
        end
        r.spread = y[TIME_W-1:0];
      end
      return r;
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] x, logic fe);
      longint xi, idx;
      xi = x;
      if (used < FRAME_MAX) begin
        idx = used;
        w_sum += xi;
        m1 += xi * idx;
        m2 += xi * idx * idx;
        used++;
      end else begin
        overflowed = 1'b1;
      end
      if (fe) begin
        pending = {pending, frame_features()};
        clear_frame();
      end
    endfunction

    function void compare_field(string name, logic [TIME_W-1:0] exp, logic [TIME_W-1:0] act);
      if (act !== exp) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t exp;
      if (pending.size() == 0) begin
        $error("result word with no frame outstanding");
        errors++;
        return;
      end
      exp = pending.pop_front();
      frames_checked++;
      compare_field("centroid_seconds", exp.centroid, got.centroid);
      compare_field("spread_seconds", exp.spread, got.spread);
      compare_field("zero_weight", exp.zero_weight, got.zero_weight);
      compare_field("saturated", exp.saturated, got.saturated);
      compare_field("frame_overflow", exp.overflow, got.overflow);
      compare_field("sample_count", exp.count, got.count);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  sample = '0;
  logic                        frame_end = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [TIME_W-1:0]    centroid_seconds;
  logic [TIME_W-1:0]           spread_seconds;
  logic                        zero_weight;
  logic                        saturated;
  logic                        frame_overflow;
  logic [COUNT_W-1:0]          sample_count;

  centroid_checker    chk;
  logic signed [15:0] frame_buf[$];
  bit                 in_idle_on = 1'b1;
  bit                 out_idle_on = 1'b1;
  int                 words_sent = 0;
  int                 frames_sent = 0;
  int                 settings_used = 1;
  int                 stall_cycles = 0;

  temporal_centroid_spread_unit #(.FRAME_MAX(FRAME_MAX)) dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Ends the run when no word has moved on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("[temporal_centroid_spread_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic send_word(input logic signed [SAMPLE_W-1:0] x, input logic fe);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= x;
    frame_end <= fe;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    chk.take_sample(x, fe);
    words_sent++;
  endtask

  task automatic send_buf();
    int k;
    for (k = 0; k < frame_buf.size(); k++) send_word(frame_buf[k], k == frame_buf.size() - 1);
    frames_sent++;
  endtask

  // Registers change only once every frame has come back and the block has
  // had time to finish any sample still in flight.
  task automatic settle_and_configure(input logic [CFG_DATA_W-1:0] per, input logic dom);
    logic [CFG_DATA_W-1:0] dom_data;
    in_valid <= 1'b0;
    while (chk.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    dom_data = {31'($urandom()), dom};
    cfg_write <= 1'b1;
    cfg_index <= REG_SAMPLE_PERIOD;
    cfg_data <= per;
    @(posedge clk);
    chk.write_reg(REG_SAMPLE_PERIOD, per);
    cfg_index <= REG_DOMAIN_MODE;
    cfg_data <= dom_data;
    @(posedge clk);
    chk.write_reg(REG_DOMAIN_MODE, dom_data);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [15:0] draw_sample(int kind);
    case (kind)
      1:       return 16'($urandom_range(0, 32767));
      2:       return 16'(-$urandom_range(1, 32768));
      3:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      4:       return 16'($urandom_range(0, 2) - 1);
      5:       return 16'($urandom_range(0, 16) - 8);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_frame();
    int r, len, kind, k;
    r = $urandom_range(0, 9);
    if (r < 8) len = $urandom_range(1, 12);
    else if (r == 8) len = $urandom_range(13, 48);
    else len = $urandom_range(49, 160);
    kind = $urandom_range(0, 5);
    frame_buf.delete();
    for (k = 0; k < len; k++) frame_buf = {frame_buf, draw_sample(kind)};
    send_buf();
  endtask

  // Output side: random back-pressure, every result word goes to the checker.
  initial begin
    int gap;
    frame_result_t got;
    while (rst) @(posedge clk);
    forever begin
      gap = out_idle_on ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      got.centroid = centroid_seconds;
      got.spread = spread_seconds;
      got.zero_weight = zero_weight;
      got.saturated = saturated;
      got.overflow = frame_overflow;
      got.count = sample_count;
      chk.check_result(got);
    end
  end

  initial begin
    int ph, start;
    logic [CFG_DATA_W-1:0] per;
    logic dom;
    chk = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset register values: single-sample frames, zero sums, negative sum.
    frame_buf = '{32767};                  send_buf();
    frame_buf = '{-32768};                 send_buf();
    frame_buf = '{0};                      send_buf();
    frame_buf = '{5, -5};                  send_buf();
    frame_buf = '{-32768, -32768, -32768, 32767}; send_buf();
    frame_buf = '{100, 200, 300};          send_buf();

    // Longest period with a tiny weight: centroid and spread clip both ways.
    settle_and_configure(32'hFFFF_FFFF, 1'b0);
    frame_buf = '{-32767, 0, 0, 0, 32767, 1};  send_buf();
    frame_buf = '{-32767, 0, 0, 0, 32767, -1}; send_buf();

    // Shortest period in the other domain.
    settle_and_configure(32'd1, 1'b1);
    frame_buf = '{1000};                   send_buf();

    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       per = 32'd1;
        1:       per = 32'hFFFF_FFFF;
        2:       per = $urandom_range(1, 1 << 20);
        3:       per = 32'h8000_0000;
        default: per = $urandom() | 32'd1;
      endcase
      dom = (ph == 5) || ($urandom_range(0, 9) == 0);
      settle_and_configure(per, dom);
      in_idle_on = (ph != 6) && ($urandom_range(0, 3) != 0);
      out_idle_on = (ph != 6) && ($urandom_range(0, 3) != 0);
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) random_frame();
    end

    in_valid <= 1'b0;
    while (chk.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);

    $display("Sent %0d samples in %0d frames under %0d register settings;",
             words_sent, frames_sent, settings_used);
    $display("checked %0d result words, with clipping and zero-sum frames.",
             chk.frames_checked);
    if (chk.errors == 0 && chk.pending.size() == 0) begin
      $display("[temporal_centroid_spread_unit] OK");
    end else begin
      $display("[temporal_centroid_spread_unit] ERROR");
    end
    $finish;
  end

endmodule
